// File: rtl/socks4_request_parser_macros.svh
// assertion macros used by the top rtl file
`ifndef SOCKS4_REQUEST_PARSER_MACROS_SVH
`define SOCKS4_REQUEST_PARSER_MACROS_SVH

// same-cycle implication, disabled while in reset
`define S4RP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define S4RP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/s4rp_pkg.sv
// ----------------------------------------------------------------------------
// s4rp_pkg
// types and constants of the socks4 request parser
// ----------------------------------------------------------------------------
package s4rp_pkg;

  localparam logic [7:0]  SOCKS_VER    = 8'h04;
  localparam logic [7:0]  CMD_CONNECT  = 8'h01;
  localparam logic [7:0]  NUL_BYTE     = 8'h00;
  localparam logic [15:0] MAX_LEN_RST  = 16'd4096;
  localparam logic [2:0]  HDR_LAST_POS = 3'd7;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_USERID   = 3'd1,
    KIND_HOST     = 3'd2,
    KIND_COMPLETE = 3'd3,
    KIND_REJECT   = 3'd4,
    KIND_OVERLONG = 3'd5,
    KIND_PAYLOAD  = 3'd6
  } kind_e;

  typedef enum logic [4:0] {
    PH_HEADER  = 5'b00001,
    PH_USERID  = 5'b00010,
    PH_HOST    = 5'b00100,
    PH_PAYLOAD = 5'b01000,
    PH_CLOSED  = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_connection;
  } item_t;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  data_out;
    logic [15:0] dest_port;
    logic [31:0] dest_ipv4;
    logic        use_hostname;
  } result_t;

endpackage

// File: rtl/s4rp_in_reg.sv
// ----------------------------------------------------------------------------
// s4rp_in_reg
// input register holding one received byte until the parser takes it
// ----------------------------------------------------------------------------
module s4rp_in_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  s4rp_pkg::item_t item_i,
  input  logic           advance_i,
  output logic           vld_o,
  output s4rp_pkg::item_t item_o
);

  logic            vld_q, vld_d;
  logic            load;
  s4rp_pkg::item_t item_q;

  // stall only while holding an item that cannot move on
  assign in_stall_o = vld_q && !advance_i;
  assign load       = in_valid_i && !in_stall_o;

  always_comb begin
    vld_d = vld_q;
    if (load) begin
      vld_d = 1'b1;
    end else if (advance_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q <= item_i;
    end
  end

  assign vld_o  = vld_q;
  assign item_o = item_q;

endmodule

// File: rtl/s4rp_parser.sv
// ----------------------------------------------------------------------------
// s4rp_parser
// request phase machine, header store and byte counter
// ----------------------------------------------------------------------------
module s4rp_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             fire_i,
  input  s4rp_pkg::item_t  item_i,
  input  logic [15:0]      max_len_i,
  output logic             emit_o,
  output s4rp_pkg::result_t res_o
);

  s4rp_pkg::phase_e phase_q, phase_d, eff_phase;
  logic [15:0]      cnt_q, cnt_d, eff_cnt;
  logic             mode_q, mode_d, eff_mode;
  logic [7:0]       hdr_q [8];
  logic [16:0]      cnt_inc;
  logic             overlong;
  logic             hdr_we;
  logic [7:0]       b;

  assign b = item_i.data_byte;

  // a new connection restarts the request before this byte
  always_comb begin
    if (item_i.new_connection) begin
      eff_phase = s4rp_pkg::PH_HEADER;
      eff_cnt   = '0;
      eff_mode  = 1'b0;
    end else begin
      eff_phase = phase_q;
      eff_cnt   = cnt_q;
      eff_mode  = mode_q;
    end
  end

  assign cnt_inc  = {1'b0, eff_cnt} + 17'd1;
  assign overlong = cnt_inc > {1'b0, max_len_i};

  always_comb begin
    phase_d = eff_phase;
    cnt_d   = eff_cnt;
    mode_d  = eff_mode;
    emit_o  = 1'b0;
    hdr_we  = 1'b0;
    res_o   = '0;
    unique case (eff_phase)
      s4rp_pkg::PH_CLOSED: begin
        // bytes dropped until a new connection
      end
      s4rp_pkg::PH_PAYLOAD: begin
        emit_o         = 1'b1;
        res_o.kind     = s4rp_pkg::KIND_PAYLOAD;
        res_o.data_out = b;
      end
      s4rp_pkg::PH_HEADER, s4rp_pkg::PH_USERID, s4rp_pkg::PH_HOST: begin
        emit_o = 1'b1;
        if (overlong) begin
          phase_d    = s4rp_pkg::PH_CLOSED;
          res_o.kind = s4rp_pkg::KIND_OVERLONG;
        end else begin
          cnt_d = cnt_inc[15:0];
          if (eff_phase == s4rp_pkg::PH_HEADER) begin
            hdr_we     = 1'b1;
            res_o.kind = s4rp_pkg::KIND_HEADER;
            if (eff_cnt[2:0] == s4rp_pkg::HDR_LAST_POS) begin
              if (hdr_q[0] != s4rp_pkg::SOCKS_VER || hdr_q[1] != s4rp_pkg::CMD_CONNECT) begin
                phase_d    = s4rp_pkg::PH_CLOSED;
                res_o.kind = s4rp_pkg::KIND_REJECT;
              end else begin
                phase_d = s4rp_pkg::PH_USERID;
                // 0.0.0.x with x nonzero selects 4a
                mode_d  = (hdr_q[4] == s4rp_pkg::NUL_BYTE) && (hdr_q[5] == s4rp_pkg::NUL_BYTE)
                          && (hdr_q[6] == s4rp_pkg::NUL_BYTE) && (b != s4rp_pkg::NUL_BYTE);
              end
            end
          end else if (b != s4rp_pkg::NUL_BYTE) begin
            res_o.data_out = b;
            res_o.kind     = (eff_phase == s4rp_pkg::PH_USERID) ? s4rp_pkg::KIND_USERID
                                                              : s4rp_pkg::KIND_HOST;
          end else if (eff_phase == s4rp_pkg::PH_USERID && eff_mode) begin
            phase_d    = s4rp_pkg::PH_HOST;
            res_o.kind = s4rp_pkg::KIND_USERID;
          end else begin
            phase_d            = s4rp_pkg::PH_PAYLOAD;
            res_o.kind         = s4rp_pkg::KIND_COMPLETE;
            res_o.dest_port    = {hdr_q[2], hdr_q[3]};
            res_o.dest_ipv4    = {hdr_q[4], hdr_q[5], hdr_q[6], hdr_q[7]};
            res_o.use_hostname = eff_mode;
          end
        end
      end
      default: begin
        phase_d = s4rp_pkg::PH_HEADER;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= s4rp_pkg::PH_HEADER;
      cnt_q   <= '0;
      mode_q  <= 1'b0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      mode_q  <= mode_d;
    end
  end

  // header bytes, each position written once per request before use
  always_ff @(posedge clk_i) begin
    if (fire_i && hdr_we) begin
      hdr_q[eff_cnt[2:0]] <= b;
    end
  end

endmodule

// File: rtl/s4rp_out_reg.sv
// ----------------------------------------------------------------------------
// s4rp_out_reg
// result register towards the consumer
// ----------------------------------------------------------------------------
module s4rp_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              emit_i,
  input  s4rp_pkg::result_t res_i,
  output logic              space_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output s4rp_pkg::result_t res_o
);

  logic              vld_q, vld_d;
  s4rp_pkg::result_t res_q;

  // free, or emptied at this edge
  assign space_o = !vld_q || !out_stall_i;

  always_comb begin
    vld_d = vld_q;
    if (load_i) begin
      vld_d = emit_i;
    end else if (!out_stall_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && emit_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = vld_q;
  assign res_o       = res_q;

endmodule

// File: rtl/socks4_request_parser.sv
// ----------------------------------------------------------------------------
// socks4_request_parser
// socks4 / socks4a connect request parser, one client byte per transaction
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+-------------------------------------
//  in       | input     | in_valid / in_stall | data_byte, new_connection
//  out      | output    | out_valid/out_stall | kind, data_out, dest_port, dest_ipv4,
//           |           |                     | use_hostname
//  cfg      | input     | cfg_valid/cfg_ready | max_request_len (16 bits)
//
//  one byte per cycle while the result side does not stall; a byte accepted into
//  the input register goes through the parser once the result register has room,
//  and its result is then loaded into the result register, where it is valid
//  reset clears the phase, byte count, mode flag and both valid flags, and
//  sets max_request_len to 4096
//  a stall on the result side with a full result register holds the byte in
//  the input register and stalls the input in that same cycle; bytes dropped
//  on a closed connection leave no result
// ----------------------------------------------------------------------------
`include "socks4_request_parser_macros.svh"

module socks4_request_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        new_connection_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [7:0]  data_out_o,
  output logic [15:0] dest_port_o,
  output logic [31:0] dest_ipv4_o,
  output logic        use_hostname_o,
  // configuration write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i
);

  s4rp_pkg::item_t   in_item, held_item;
  s4rp_pkg::result_t step_res, out_res;
  logic              held_vld;
  logic              out_space;
  logic              advance;
  logic              step_emit;
  logic [15:0]       max_len_q;

  // configuration register, always ready
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= s4rp_pkg::MAX_LEN_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign in_item.data_byte      = data_byte_i;
  assign in_item.new_connection = new_connection_i;

  // the held byte moves through the parser whenever the result register
  // has room for its result
  assign advance = held_vld && out_space;

  s4rp_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .advance_i  (advance),
    .vld_o      (held_vld),
    .item_o     (held_item)
  );

  s4rp_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (advance),
    .item_i    (held_item),
    .max_len_i (max_len_q),
    .emit_o    (step_emit),
    .res_o     (step_res)
  );

  s4rp_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .emit_i      (step_emit),
    .res_i       (step_res),
    .space_o     (out_space),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign kind_o         = out_res.kind;
  assign data_out_o     = out_res.data_out;
  assign dest_port_o    = out_res.dest_port;
  assign dest_ipv4_o    = out_res.dest_ipv4;
  assign use_hostname_o = out_res.use_hostname;

  // input only stalls behind a stalled, full result register
  `S4RP_ASSERT_IMP(a_stall_cause, in_stall_o, out_valid_o && out_stall_i,
                   "input stall without output backpressure")
  // header fields only travel with a completion
  `S4RP_ASSERT_IMP(a_fields_complete,
                   out_valid_o && kind_o != s4rp_pkg::KIND_COMPLETE,
                   dest_port_o == 16'd0 && dest_ipv4_o == 32'd0 && !use_hostname_o,
                   "destination fields set outside completion")
  // no echo on header, completion, reject or overlong results
  `S4RP_ASSERT_IMP(a_no_echo,
                   out_valid_o && (kind_o == s4rp_pkg::KIND_HEADER ||
                   kind_o == s4rp_pkg::KIND_COMPLETE || kind_o == s4rp_pkg::KIND_REJECT ||
                   kind_o == s4rp_pkg::KIND_OVERLONG),
                   data_out_o == 8'd0, "data echoed on a non-data kind")
  // a held result stays until taken
  `S4RP_ASSERT_NXT(a_hold_result, out_valid_o && out_stall_i,
                   out_valid_o && $stable(kind_o), "stalled result changed")

endmodule

// File: dv/socks4_request_checker.sv
// ----------------------------------------------------------------------------
// socks4_request_checker
// watches the byte, result and configuration channels of the request parser,
// works out the result, if any, of every accepted byte and compares it with what the
// parser delivers, oldest expectation first
// ----------------------------------------------------------------------------
module socks4_request_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [7:0]  data_byte_i,
  input  logic        new_connection_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [7:0]  data_out_i,
  input  logic [15:0] dest_port_i,
  input  logic [31:0] dest_ipv4_i,
  input  logic        use_hostname_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [15:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);

  // own copy of the parser state and its length limit
  s4rp_pkg::phase_e  req_phase;
  logic [63:0]       hdr_bytes;
  logic [15:0]       req_len;
  logic              host_mode;
  logic [15:0]       len_limit;

  s4rp_pkg::result_t expected_results[$];
  s4rp_pkg::result_t parsed;
  s4rp_pkg::result_t want;
  int                mismatches;

  function automatic void clear_request();
    req_phase = s4rp_pkg::PH_HEADER;
    hdr_bytes = '0;
    req_len   = '0;
    host_mode = 1'b0;
  endfunction

  // result of one client byte, 0 when the byte is dropped
  function automatic bit parse_byte(input logic [7:0] b, input logic nc,
                                    output s4rp_pkg::result_t r);
    logic [16:0] next_len;
    logic [2:0]  pos;
    logic        finished;
    r        = '0;
    r.kind   = s4rp_pkg::KIND_HEADER;
    finished = 1'b0;
    if (nc) clear_request();
    if (req_phase == s4rp_pkg::PH_CLOSED) return 1'b0;
    if (req_phase == s4rp_pkg::PH_PAYLOAD) begin
      r.kind     = s4rp_pkg::KIND_PAYLOAD;
      r.data_out = b;
      return 1'b1;
    end
    // in the request phases the length test comes before anything else, header check included
    next_len = {1'b0, req_len} + 17'd1;
    if (next_len > {1'b0, len_limit}) begin
      req_phase = s4rp_pkg::PH_CLOSED;
      r.kind    = s4rp_pkg::KIND_OVERLONG;
      return 1'b1;
    end
    req_len = next_len[15:0];
    case (req_phase)
      s4rp_pkg::PH_HEADER: begin
        pos       = req_len[2:0] - 3'd1;
        hdr_bytes = hdr_bytes | ({56'd0, b} << (8 * (7 - pos)));
        if (pos == s4rp_pkg::HDR_LAST_POS) begin
          if (hdr_bytes[63:56] != s4rp_pkg::SOCKS_VER ||
              hdr_bytes[55:48] != s4rp_pkg::CMD_CONNECT) begin
            req_phase = s4rp_pkg::PH_CLOSED;
            r.kind    = s4rp_pkg::KIND_REJECT;
          end else begin
            host_mode = (hdr_bytes[31:8] == 24'd0) && (hdr_bytes[7:0] != s4rp_pkg::NUL_BYTE);
            req_phase = s4rp_pkg::PH_USERID;
          end
        end
      end
      s4rp_pkg::PH_USERID: begin
        if (b != s4rp_pkg::NUL_BYTE) begin
          r.kind     = s4rp_pkg::KIND_USERID;
          r.data_out = b;
        end else if (host_mode) begin
          req_phase = s4rp_pkg::PH_HOST;
          r.kind    = s4rp_pkg::KIND_USERID;
        end else begin
          finished = 1'b1;
        end
      end
      default: begin
        if (b != s4rp_pkg::NUL_BYTE) begin
          r.kind     = s4rp_pkg::KIND_HOST;
          r.data_out = b;
        end else begin
          finished = 1'b1;
        end
      end
    endcase
    if (finished) begin
      req_phase      = s4rp_pkg::PH_PAYLOAD;
      r.kind         = s4rp_pkg::KIND_COMPLETE;
      r.dest_port    = hdr_bytes[47:32];
      r.dest_ipv4    = hdr_bytes[31:0];
      r.use_hostname = host_mode;
    end
    return 1'b1;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      mismatches++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, exp_val,
               act_val);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_request();
      len_limit = s4rp_pkg::MAX_LEN_RST;
      expected_results.delete();
      mismatches = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          $display("%0t: result of kind %0d with nothing expected, expected none, actual %0d",
                   $time, kind_i, kind_i);
        end else begin
          want = expected_results.pop_front();
          check_field("kind", {29'd0, want.kind}, {29'd0, kind_i});
          check_field("data_out", {24'd0, want.data_out}, {24'd0, data_out_i});
          check_field("dest_port", {16'd0, want.dest_port}, {16'd0, dest_port_i});
          check_field("dest_ipv4", want.dest_ipv4, dest_ipv4_i);
          check_field("use_hostname", {31'd0, want.use_hostname}, {31'd0, use_hostname_i});
        end
      end
      if (cfg_valid_i && cfg_ready_i) len_limit = cfg_data_i;
      if (in_valid_i && !in_stall_i) begin
        if (parse_byte(data_byte_i, new_connection_i, parsed))
          expected_results.push_back(parsed);
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_results.size();
    end
  end

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// drives client bytes and length limit writes into the socks4 request parser
// and gives the verdict; all prediction and comparison sits in the checker
// ----------------------------------------------------------------------------
module tb_top;

  // cycles allowed for a dropped byte to leave the pipeline before a write
  localparam int DRAIN_CYCLES = 6;
  // generous fixed run limit, far beyond the slowest correct run
  localparam int RUN_LIMIT    = 12 * 400000;
  // random bytes per length limit setting
  localparam int PHASE_BYTES  = 220;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  data_byte;
  logic        new_conn;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  kind;
  logic [7:0]  data_out;
  logic [15:0] dest_port;
  logic [31:0] dest_ipv4;
  logic        use_hostname;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [15:0] cfg_data;

  int          fail_count;
  int          pending;

  // sender burst shaping
  int          burst_left;
  int          gap_max;
  // run statistics for the summary
  int          bytes_sent;
  int          requests_sent;
  int          noise_bytes;
  int          limit_writes;

  // receiver stall pattern
  stall_mode_e stall_mode = STALL_NONE;
  logic [7:0]  stall_cycle = 8'd0;

  // bytes of the request being sent
  logic [7:0]  req_bytes[$];
  logic [15:0] limit_list[$];

  socks4_request_parser dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .data_byte_i      (data_byte),
    .new_connection_i (new_conn),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .kind_o           (kind),
    .data_out_o       (data_out),
    .dest_port_o      (dest_port),
    .dest_ipv4_o      (dest_ipv4),
    .use_hostname_o   (use_hostname),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data)
  );

  socks4_request_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_stall_i       (in_stall),
    .data_byte_i      (data_byte),
    .new_connection_i (new_conn),
    .out_valid_i      (out_valid),
    .out_stall_i      (out_stall),
    .kind_i           (kind),
    .data_out_i       (data_out),
    .dest_port_i      (dest_port),
    .dest_ipv4_i      (dest_ipv4),
    .use_hostname_i   (use_hostname),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .fail_count_o     (fail_count),
    .pending_o        (pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // receiver: a new stall mode each time the stall_cycle counter wraps, including
  // long stretches with no stall at all
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 8'd1;
    if (stall_cycle == 8'd0) begin
      case ($urandom_range(0, 3))
        0:       stall_mode <= STALL_NONE;
        1:       stall_mode <= STALL_LIGHT;
        2:       stall_mode <= STALL_HEAVY;
        default: stall_mode <= STALL_PERIODIC;
      endcase
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 6);
      default:     out_stall <= (stall_cycle[1:0] == 2'd0);
    endcase
  end

  function automatic logic [7:0] rand_byte(input int lo);
    int unsigned r;
    r = $urandom_range(lo, 255);
    return r[7:0];
  endfunction

  // one byte transaction; valid stays high into the next byte while a burst
  // lasts, and once it ends drops for a random gap that may be zero
  task automatic push_byte(input logic [7:0] b, input logic nc);
    int gap;
    in_valid  <= 1'b1;
    data_byte <= b;
    new_conn  <= nc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 24);
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // sends the first count bytes of req_bytes, the first one possibly
  // opening a new connection
  task automatic send_req_bytes(input int count, input logic first_nc);
    for (int i = 0; i < count; i++) push_byte(req_bytes[i], (i == 0) ? first_nc : 1'b0);
    requests_sent++;
  endtask

  // sender holds off until every expected result has come, then lets a
  // dropped byte clear the pipeline too
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_len_limit(input logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    limit_writes++;
  endtask

  // builds a request: well formed with random content or, if not, with a random
  // version or command; some get cut short
  task automatic send_request(input bit well_formed);
    int unsigned r;
    logic [7:0]  ver;
    logic [7:0]  cmd;
    logic [15:0] port;
    logic [31:0] addr;
    int          cut;
    ver = s4rp_pkg::SOCKS_VER;
    cmd = s4rp_pkg::CMD_CONNECT;
    if (!well_formed) begin
      case ($urandom_range(0, 2))
        0:       ver = rand_byte(0);
        1:       cmd = rand_byte(0);
        default: begin
          ver = rand_byte(0);
          cmd = rand_byte(0);
        end
      endcase
    end
    r    = $urandom;
    port = r[15:0];
    case ($urandom_range(0, 4))
      0, 1:    addr = {24'd0, rand_byte(0)};
      // one stray high bit, so not a 4a address
      2:       addr = (32'd1 << $urandom_range(8, 31)) | {24'd0, rand_byte(0)};
      default: addr = $urandom;
    endcase
    req_bytes.delete();
    req_bytes.push_back(ver);
    req_bytes.push_back(cmd);
    req_bytes.push_back(port[15:8]);
    req_bytes.push_back(port[7:0]);
    req_bytes.push_back(addr[31:24]);
    req_bytes.push_back(addr[23:16]);
    req_bytes.push_back(addr[15:8]);
    req_bytes.push_back(addr[7:0]);
    // user id up to its terminator
    repeat ($urandom_range(0, 5)) req_bytes.push_back(rand_byte(1));
    req_bytes.push_back(s4rp_pkg::NUL_BYTE);
    // 4a host name up to its terminator
    if (addr[31:8] == 24'd0 && addr[7:0] != s4rp_pkg::NUL_BYTE) begin
      repeat ($urandom_range(0, 8)) req_bytes.push_back(rand_byte(1));
      req_bytes.push_back(s4rp_pkg::NUL_BYTE);
    end
    repeat ($urandom_range(0, 6)) req_bytes.push_back(rand_byte(0));
    cut = req_bytes.size();
    if (!well_formed || $urandom_range(0, 9) == 0) cut = $urandom_range(1, req_bytes.size());
    send_req_bytes(cut, $urandom_range(0, 9) != 0);
  endtask

  initial begin
    int phase_end;
    int pick;
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    data_byte  <= 8'd0;
    new_conn   <= 1'b0;
    cfg_valid  <= 1'b0;
    cfg_data   <= 16'd0;
    burst_left = 0;
    gap_max    = 4;
    bytes_sent    = 0;
    requests_sent = 0;
    noise_bytes   = 0;
    limit_writes  = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: 4a request under the reset limit, extreme header bytes,
    // user id terminator reported as a user id byte, a zero payload byte
    req_bytes = '{8'h04, 8'h01, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h01,
                  8'hFF, 8'h00, 8'h80, 8'h00, 8'h00};
    send_req_bytes(req_bytes.size(), 1'b1);
    // wrong command gets rejected; the byte after it is dropped
    req_bytes = '{8'h04, 8'h02, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
    send_req_bytes(req_bytes.size(), 1'b1);
    wait_drained();
    // smallest limit: a good header followed by one byte too many
    write_len_limit(16'd8);
    req_bytes = '{8'h04, 8'h01, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00, 8'h00, 8'h01};
    send_req_bytes(req_bytes.size(), 1'b1);

    // random: one pass per limit setting, the extremes among them
    limit_list = '{16'd8, 16'd65535, 16'd12, 16'd4096, 16'd20, 16'd9};
    limit_list.push_back(16'($urandom_range(10, 40)));
    foreach (limit_list[s]) begin
      if (s > 0) begin
        wait_drained();
        write_len_limit(limit_list[s]);
      end
      gap_max   = $urandom_range(1, 8);
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          send_request(1'b1);
        end else if (pick < 85) begin
          send_request(1'b0);
        end else begin
          // noise: loose bytes, now and then restarting the connection
          repeat ($urandom_range(1, 6)) begin
            push_byte(rand_byte(0), $urandom_range(0, 5) == 0);
            noise_bytes++;
          end
        end
        if ($urandom_range(0, 63) == 0) wait_drained();
      end
    end

    wait_drained();
    $display("summary: %0d bytes sent (%0d requests, %0d noise bytes)", bytes_sent,
             requests_sent, noise_bytes);
    $display("summary: %0d length limit writes, limits from 8 up to 65535", limit_writes);
    if (fail_count == 0) begin
      $display("PASS socks4_request_parser");
    end else begin
      $display("FAIL socks4_request_parser");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(RUN_LIMIT);
    $display("FAIL socks4_request_parser");
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl
rtl/s4rp_pkg.sv
rtl/s4rp_in_reg.sv
rtl/s4rp_parser.sv
rtl/s4rp_out_reg.sv
rtl/socks4_request_parser.sv
dv/socks4_request_checker.sv
dv/tb_top.sv
